[rtl/core/sha1_pkg.sv]
// SHA-1 engine package: shared types, constants and round functions.
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] INIT0_RST = 32'h67452301;
	localparam logic [31:0] INIT1_RST = 32'hEFCDAB89;
	localparam logic [31:0] INIT2_RST = 32'h98BADCFE;
	localparam logic [31:0] INIT3_RST = 32'h10325476;
	localparam logic [31:0] INIT4_RST = 32'hC3D2E1F0;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 61;
	localparam logic [CFG_IDX_W-1:0] REG_INIT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 3'd5;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	// datapath command from controller
	typedef struct packed {
		logic start_msg;   // load chain from init, clear counts
		logic put_byte;    // write byte_val at fill position
		logic [7:0] byte_val;
		logic count_byte;  // increment byte total
		logic put_len;     // write length words 14/15
		logic comp_start;  // load round regs from chain
		logic comp_round;  // run one round
		logic comp_fold;   // add round regs into chain
		logic out_shift;   // rotate chain for output
	} sha1_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [6:0] round;
	} sha1_sts_t;

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] r;
		if (t < 7'd20) r = (b & c) | (~b & d);
		else if (t < 7'd40) r = b ^ c ^ d;
		else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
		else r = b ^ c ^ d;
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] r;
		if (t < 7'd20) r = 32'h5A827999;
		else if (t < 7'd40) r = 32'h6ED9EBA1;
		else if (t < 7'd60) r = 32'h8F1BBCDC;
		else r = 32'hCA62C1D6;
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/core/sha1_datapath.sv]
// SHA-1 datapath: block store, schedule window, round and chain registers.
`default_nettype none
module sha1_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire sha1_pkg::sha1_cmd_t cmd,
	input wire logic [31:0] init_w [5],
	input wire logic [60:0] prefix_bytes,
	output sha1_pkg::sha1_sts_t sts,
	output logic [31:0] out_word
);
	logic [31:0] win_q [16];
	logic [31:0] rr_q [5];
	logic [31:0] ch_q [5];
	logic [60:0] total_q;
	logic [5:0] fill_q;
	logic [6:0] round_q;
	logic [60:0] total_cur;
	logic [5:0] fill_cur;
	logic [54:0] pre_blocks;
	logic [63:0] bits;
	logic [31:0] w_new, w_cur, tmp, wmask, wval;
	logic [1:0] bsel;

	// padded prefix in 64-byte units, ceil((p+9)/64), kept modulo 2^55
	always_comb begin
		logic [61:0] s;
		s = {1'b0, prefix_bytes} + 62'd72;
		pre_blocks = (prefix_bytes != '0) ? s[60:6] : '0;
	end
	assign bits = {total_q, 3'b000} + {pre_blocks, 9'd0};

	// a new message counts from zero in its first transaction
	assign total_cur = cmd.start_msg ? '0 : total_q;
	assign fill_cur = cmd.start_msg ? '0 : fill_q;

	assign w_new = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
		win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};
	assign w_cur = (round_q < 7'd16) ? win_q[0] : w_new;
	assign tmp = {rr_q[0][26:0], rr_q[0][31:27]} + sha1_pkg::round_f(round_q, rr_q[1],
		rr_q[2], rr_q[3]) + rr_q[4] + w_cur + sha1_pkg::round_k(round_q);
	assign bsel = fill_cur[1:0];
	assign wmask = 32'hFF000000 >> {bsel, 3'b000};
	assign wval = {cmd.byte_val, 24'd0} >> {bsel, 3'b000};

	assign sts.fill = fill_q;
	assign sts.round = round_q;
	assign out_word = ch_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			fill_q <= '0;
			round_q <= '0;
			for (int i = 0; i < 5; i++) begin
				rr_q[i] <= '0;
			end
			ch_q[0] <= sha1_pkg::INIT0_RST;
			ch_q[1] <= sha1_pkg::INIT1_RST;
			ch_q[2] <= sha1_pkg::INIT2_RST;
			ch_q[3] <= sha1_pkg::INIT3_RST;
			ch_q[4] <= sha1_pkg::INIT4_RST;
		end else begin
			if (cmd.start_msg) begin
				for (int i = 0; i < 5; i++) begin
					ch_q[i] <= init_w[i];
				end
				total_q <= '0;
				fill_q <= '0;
			end
			if (cmd.count_byte) begin
				total_q <= total_cur + 61'd1;
			end
			if (cmd.put_byte) begin
				fill_q <= fill_cur + 6'd1;
			end
			if (cmd.comp_start) begin
				for (int i = 0; i < 5; i++) begin
					rr_q[i] <= ch_q[i];
				end
				round_q <= '0;
			end
			if (cmd.comp_round) begin
				rr_q[0] <= tmp;
				rr_q[1] <= rr_q[0];
				rr_q[2] <= {rr_q[1][1:0], rr_q[1][31:2]};
				rr_q[3] <= rr_q[2];
				rr_q[4] <= rr_q[3];
				round_q <= round_q + 7'd1;
			end
			if (cmd.comp_fold) begin
				for (int i = 0; i < 5; i++) begin
					ch_q[i] <= ch_q[i] + rr_q[i];
				end
			end
			if (cmd.out_shift) begin
				for (int i = 0; i < 4; i++) begin
					ch_q[i] <= ch_q[i+1];
				end
				ch_q[4] <= ch_q[0];
			end
		end
	end

	// window: written in place at word fill/4 while filling, shifted while rounding
	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			if (bsel == 2'd0) win_q[fill_cur[5:2]] <= wval;
			else win_q[fill_cur[5:2]] <= (win_q[fill_cur[5:2]] & ~wmask) | wval;
		end
		if (cmd.put_len) begin
			win_q[14] <= bits[63:32];
			win_q[15] <= bits[31:0];
		end
		if (cmd.comp_round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_cur;
		end
	end
endmodule
`default_nettype wire

[rtl/core/sha1_ctrl.sv]
// SHA-1 controller: input acceptance, padding, round sequencing, digest output.
`default_nettype none
module sha1_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	input wire logic no_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] word_index,
	output logic last_word,
	input wire sha1_pkg::sha1_sts_t sts,
	output sha1_pkg::sha1_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MSG, ST_PAD, ST_RUN, ST_FOLD, ST_OUT
	} state_t;
	state_t state_q;
	logic final_q;   // 0x80 pad byte has been placed for this message
	logic pend_last_q, done_q;
	logic acc;

	assign in_stall = !(state_q == ST_IDLE || state_q == ST_MSG);
	assign acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE, ST_MSG: begin
				cmd.start_msg = acc && (state_q == ST_IDLE);
				cmd.put_byte = acc && !no_byte;
				cmd.count_byte = acc && !no_byte;
				cmd.byte_val = data_byte;
				cmd.comp_start = acc && !no_byte && (sts.fill == 6'd63);
				if (state_q == ST_IDLE) cmd.comp_start = 1'b0;
			end
			ST_PAD: begin
				if (final_q && sts.fill == 6'd56) begin
					cmd.put_len = 1'b1;
					cmd.comp_start = 1'b1;
				end else begin
					cmd.put_byte = 1'b1;
					cmd.byte_val = final_q ? 8'h00 : 8'h80;
					cmd.comp_start = (sts.fill == 6'd63);
				end
			end
			ST_RUN: cmd.comp_round = 1'b1;
			ST_FOLD: cmd.comp_fold = 1'b1;
			ST_OUT: cmd.out_shift = !out_stall;
			default: cmd = '0;
		endcase
	end

	// final_q in PAD: 0 before the 0x80 byte is placed, 1 after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			pend_last_q <= 1'b0;
			done_q <= 1'b0;
			word_index <= '0;
			last_word <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_MSG: begin
					if (acc) begin
						final_q <= 1'b0;
						pend_last_q <= last_byte;
						if (cmd.comp_start) begin
							state_q <= ST_RUN;
						end else if (last_byte) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_MSG;
						end
					end
				end
				ST_PAD: begin
					final_q <= 1'b1;
					if (cmd.put_len) begin
						done_q <= 1'b1;
						state_q <= ST_RUN;
					end else if (cmd.comp_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: if (sts.round == sha1_pkg::LAST_ROUND) state_q <= ST_FOLD;
				ST_FOLD: begin
					if (done_q) begin
						state_q <= ST_OUT;
						word_index <= '0;
						last_word <= 1'b0;
					end else if (pend_last_q) state_q <= ST_PAD;
					else state_q <= ST_MSG;
				end
				ST_OUT: begin
					if (!out_stall) begin
						word_index <= word_index + 3'd1;
						last_word <= (word_index == 3'd3);
						if (last_word) begin
							state_q <= ST_IDLE;
							done_q <= 1'b0;
							pend_last_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/sha1_hash_engine_unit.sv]
// SHA-1 engine top level: configuration registers, controller and datapath.
// Bytes are accepted while in_stall is low; a full block then runs 80 rounds and a fold.
// Message end: padding bytes up to offset 56, then the length words, one or two
// compressions, then five digest words, one per cycle while out_stall is low.
// Input stalls during padding, compression and output, as the single round unit is shared.
// Reset: asynchronous; init words to the standard SHA-1 values, prefix zero.
`default_nettype none
module sha1_hash_engine_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sha1_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sha1_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	input wire logic no_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	logic [31:0] init_q [5];
	logic [60:0] prefix_q;
	sha1_pkg::sha1_cmd_t cmd;
	sha1_pkg::sha1_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q[0] <= sha1_pkg::INIT0_RST;
			init_q[1] <= sha1_pkg::INIT1_RST;
			init_q[2] <= sha1_pkg::INIT2_RST;
			init_q[3] <= sha1_pkg::INIT3_RST;
			init_q[4] <= sha1_pkg::INIT4_RST;
			prefix_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sha1_pkg::REG_INIT0: init_q[0] <= cfg_data[31:0];
				sha1_pkg::REG_INIT1: init_q[1] <= cfg_data[31:0];
				sha1_pkg::REG_INIT2: init_q[2] <= cfg_data[31:0];
				sha1_pkg::REG_INIT3: init_q[3] <= cfg_data[31:0];
				sha1_pkg::REG_INIT4: init_q[4] <= cfg_data[31:0];
				sha1_pkg::REG_PREFIX: prefix_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sha1_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte), .no_byte(no_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.word_index(word_index), .last_word(last_word),
		.sts(sts), .cmd(cmd)
	);

	sha1_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.init_w(init_q), .prefix_bytes(prefix_q),
		.sts(sts), .out_word(digest_word)
	);
endmodule
`default_nettype wire
